// ----- hw/rtl/ffha_pkg.sv -----
// Shared types, sizes and codes of the first-fit heap allocator.
// No dependencies; used by ffha_table_ram and first_fit_heap_allocator.
package ffha_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 8;

    localparam int ADDR_W = 32;
    localparam int REQ_W  = 25;
    localparam int SIZE_W = REQ_W + 1;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    // running payload address: base plus a full table of sizes
    localparam int PAY_W  = ADDR_W + 2;

    localparam logic [ADDR_W-1:0] BASE_RESET  = 32'hA2C0_0000;
    localparam logic [ADDR_W-1:0] LIMIT_RESET = 32'hA400_0000;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_BADFREE = 2'd2;

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } tbl_wr_t;

endpackage

// ----- hw/rtl/ffha_table_ram.sv -----
// Block table storage: one write port, one read port, registered read data.
// Depends on ffha_pkg for the entry and write-port types.
module ffha_table_ram (
    input  logic                    clk,
    input  ffha_pkg::tbl_wr_t       wr,
    input  logic [ffha_pkg::IDX_W-1:0] rd_idx,
    output ffha_pkg::entry_t        rd_data
);
    import ffha_pkg::*;

    entry_t mem [MAX_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
        rd_data <= mem[rd_idx];
    end

endmodule

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// First-fit heap allocator, top level. Holds the block table RAM (ffha_table_ram)
// and the scan sequencer. Depends on ffha_pkg.
//
// Usage: a transaction is accepted on a clock edge where start is high and busy
// is low. An allocate walks the block table from entry 0 and takes the first
// free block that holds request_size plus the header; if none fits it appends a
// block at the heap top, unless the table is full or the new top would pass the
// limit. A release walks the table looking for the block whose payload starts at
// release_address. The walk reads one table entry per cycle from a RAM with
// registered read data and ends at the first hit. The result appears in the cycle
// after the walk with done high for exactly one cycle; the receiver cannot stall
// it, and busy is already low in that cycle so the next transaction may be
// started at once. Blocks are never split or merged. Writing heap_base empties
// the heap; write the configuration only while busy is low and no result is
// pending.
module first_fit_heap_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write port
    input  logic                        wr_en,
    input  logic                        wr_index,
    input  logic [ffha_pkg::ADDR_W-1:0] wr_data,
    // request
    input  logic                        start,
    output logic                        busy,
    input  logic                        operation,
    input  logic [ffha_pkg::REQ_W-1:0]  request_size,
    input  logic [ffha_pkg::ADDR_W-1:0] release_address,
    // result
    output logic                        done,
    output logic [1:0]                  status,
    output logic [ffha_pkg::ADDR_W-1:0] payload_address
);
    import ffha_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // configuration and heap bookkeeping
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] limit_reg, limit_next;
    logic [ADDR_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // current transaction
    logic              op_reg, op_next;
    logic [SIZE_W-1:0] need_reg, need_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    // scan pipeline: issue stage reads the RAM, check stage looks at the data
    logic [CNT_W-1:0]  issue_idx_reg, issue_idx_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              chk_vld_reg, chk_vld_next;
    // payload address of the entry in the check stage (its base + header)
    logic [PAY_W-1:0]  pay_reg, pay_next;

    // result registers
    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [ADDR_W-1:0] paddr_reg, paddr_next;

    tbl_wr_t           tbl_wr;
    entry_t            tbl_q;
    logic [IDX_W-1:0]  rd_idx;

    logic              alloc_hit;
    logic              rel_match;
    logic              scan_end;
    logic [ADDR_W:0]   new_top;

    ffha_table_ram u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_idx  (rd_idx),
        .rd_data (tbl_q)
    );

    // Reads are issued every cycle; the data is only consumed while chk_vld_reg.
    // The only table write of a transaction happens on its final edge, so the
    // next transaction's first read already sees it.
    assign rd_idx = issue_idx_reg[IDX_W-1:0];

    assign alloc_hit = chk_vld_reg && (op_reg == OP_ALLOC) && !tbl_q.used
                       && (tbl_q.size >= need_reg);
    assign rel_match = chk_vld_reg && (op_reg == OP_RELEASE)
                       && (pay_reg == {{(PAY_W-ADDR_W){1'b0}}, addr_reg});
    assign scan_end  = !chk_vld_reg && (issue_idx_reg >= count_reg);
    assign new_top   = {1'b0, top_reg} + {{(ADDR_W+1-SIZE_W){1'b0}}, need_reg};

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        limit_next     = limit_reg;
        top_next       = top_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        need_next      = need_reg;
        addr_next      = addr_reg;
        issue_idx_next = issue_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_vld_next   = 1'b0;
        pay_next       = pay_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        paddr_next     = paddr_reg;
        tbl_wr         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next        = operation;
                    need_next      = {1'b0, request_size} + SIZE_W'(HEADER_BYTES);
                    addr_next      = release_address;
                    issue_idx_next = '0;
                    pay_next       = {{(PAY_W-ADDR_W){1'b0}}, base_reg}
                                     + PAY_W'(HEADER_BYTES);
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // issue stage
                if (issue_idx_reg < count_reg)
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                    chk_idx_next   = issue_idx_reg[IDX_W-1:0];
                    chk_vld_next   = 1'b1;
                end

                // check stage
                if (alloc_hit)
                begin
                    tbl_wr.en        = 1'b1;
                    tbl_wr.idx       = chk_idx_reg;
                    tbl_wr.data.used = 1'b1;
                    tbl_wr.data.size = tbl_q.size;
                    status_next      = STAT_OK;
                    paddr_next       = pay_reg[ADDR_W-1:0];
                    done_next        = 1'b1;
                    state_next       = ST_IDLE;
                end
                else if (rel_match)
                begin
                    if (tbl_q.used)
                    begin
                        tbl_wr.en        = 1'b1;
                        tbl_wr.idx       = chk_idx_reg;
                        tbl_wr.data.used = 1'b0;
                        tbl_wr.data.size = tbl_q.size;
                        status_next      = STAT_OK;
                    end
                    else
                    begin
                        status_next = STAT_BADFREE;
                    end
                    paddr_next = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (chk_vld_reg)
                begin
                    pay_next = pay_reg + {{(PAY_W-SIZE_W){1'b0}}, tbl_q.size};
                end
                else if (scan_end)
                begin
                    // whole table walked without a hit
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    paddr_next = '0;
                    if (op_reg == OP_RELEASE)
                    begin
                        status_next = STAT_BADFREE;
                    end
                    else if (count_reg == CNT_W'(MAX_BLOCKS))
                    begin
                        status_next = STAT_NOSPACE;
                    end
                    else if (new_top > {1'b0, limit_reg})
                    begin
                        status_next = STAT_NOSPACE;
                    end
                    else
                    begin
                        tbl_wr.en        = 1'b1;
                        tbl_wr.idx       = count_reg[IDX_W-1:0];
                        tbl_wr.data.used = 1'b1;
                        tbl_wr.data.size = need_reg;
                        count_next       = count_reg + 1'b1;
                        top_next         = new_top[ADDR_W-1:0];
                        status_next      = STAT_OK;
                        paddr_next       = top_reg + ADDR_W'(HEADER_BYTES);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration writes must arrive only while idle; the block does not check this
        if (wr_en)
        begin
            unique case (wr_index)
                REG_HEAP_BASE:
                begin
                    base_next  = wr_data;
                    top_next   = wr_data;
                    count_next = '0;
                end
                REG_HEAP_LIMIT:
                begin
                    limit_next = wr_data;
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= BASE_RESET;
            limit_reg     <= LIMIT_RESET;
            top_reg       <= BASE_RESET;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            chk_vld_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            limit_reg     <= limit_next;
            top_reg       <= top_next;
            count_reg     <= count_next;
            issue_idx_reg <= issue_idx_next;
            chk_vld_reg   <= chk_vld_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        need_reg    <= need_next;
        addr_reg    <= addr_next;
        chk_idx_reg <= chk_idx_next;
        pay_reg     <= pay_next;
        status_reg  <= status_next;
        paddr_reg   <= paddr_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign payload_address = paddr_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count above table depth");

    a_chk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> ({1'b0, chk_idx_reg} < count_reg))
        else $error("checking an entry beyond block count");

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_SCAN))
        else $error("result without a scan");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> (payload_address == '0))
        else $error("failed transaction returned an address");

    a_release_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && op_reg == OP_RELEASE) |-> (payload_address == '0))
        else $error("release returned an address");
`endif

endmodule

// ----- dv/ffha_checker.sv -----
// Scoreboard for the first-fit heap allocator: watches the config, request and result ports,
// predicts each result and compares it. Depends on ffha_pkg.
module ffha_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic                        wr_index,
    input  logic [ffha_pkg::ADDR_W-1:0] wr_data,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        operation,
    input  logic [ffha_pkg::REQ_W-1:0]  request_size,
    input  logic [ffha_pkg::ADDR_W-1:0] release_address,
    input  logic                        done,
    input  logic [1:0]                  status,
    input  logic [ffha_pkg::ADDR_W-1:0] payload_address,
    input  logic                        drain_done,
    output int                          outstanding,
    output int                          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int PRINT_CAP = 30;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
    } heap_result_t;

    // shadow heap
    logic [ADDR_W-1:0] cfg_base;
    logic [ADDR_W-1:0] cfg_limit;
    logic [ADDR_W-1:0] heap_top;
    entry_t            blocks [MAX_BLOCKS];
    int                n_blocks;

    heap_result_t expected_results[$];
    int errors;
    int n_ok, n_nospace, n_badfree;
    bit drained;

    assign fail_count = errors;

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] exp_v,
                                   input logic [ADDR_W-1:0] got_v);
        if (errors < PRINT_CAP)
            $display("[%0t] ERROR %s: expected 0x%08h, got 0x%08h", $realtime, what,
                     exp_v, got_v);
        errors++;
    endtask

    function automatic heap_result_t predict_allocate(input logic [REQ_W-1:0] req);
        logic [SIZE_W-1:0] need;
        logic [PAY_W-1:0]  at;
        logic [PAY_W-1:0]  new_top;
        heap_result_t      r;
        need     = SIZE_W'(req) + SIZE_W'(HEADER_BYTES);
        at       = PAY_W'(cfg_base);
        r.status = STAT_NOSPACE;
        r.addr   = '0;
        // first fit over existing blocks, no split
        for (int i = 0; i < n_blocks; i++)
        begin
            if (!blocks[i].used && blocks[i].size >= need)
            begin
                blocks[i].used = 1'b1;
                r.status = STAT_OK;
                r.addr   = ADDR_W'(at + PAY_W'(HEADER_BYTES));
                return r;
            end
            at += PAY_W'(blocks[i].size);
        end
        if (n_blocks >= MAX_BLOCKS)
            return r;
        new_top = PAY_W'(heap_top) + PAY_W'(need);
        if (new_top > PAY_W'(cfg_limit))
            return r;
        blocks[n_blocks].used = 1'b1;
        blocks[n_blocks].size = need;
        n_blocks++;
        r.status = STAT_OK;
        r.addr   = heap_top + ADDR_W'(HEADER_BYTES);
        heap_top = ADDR_W'(new_top);
        return r;
    endfunction

    function automatic heap_result_t predict_release(input logic [ADDR_W-1:0] addr);
        logic [PAY_W-1:0] at;
        heap_result_t     r;
        at       = PAY_W'(cfg_base);
        r.status = STAT_BADFREE;
        r.addr   = '0;
        for (int i = 0; i < n_blocks; i++)
        begin
            if (at + PAY_W'(HEADER_BYTES) == PAY_W'(addr))
            begin
                if (blocks[i].used)
                begin
                    blocks[i].used = 1'b0;
                    r.status = STAT_OK;
                end
                return r;
            end
            at += PAY_W'(blocks[i].size);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        heap_result_t exp_r;
        if (!rst_n)
        begin
            cfg_base    = BASE_RESET;
            cfg_limit   = LIMIT_RESET;
            heap_top    = BASE_RESET;
            n_blocks    = 0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // result first: it belongs to a transaction already queued
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no transaction pending", '0, payload_address);
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (status !== exp_r.status)
                        report_mismatch("status", ADDR_W'(exp_r.status), ADDR_W'(status));
                    if (payload_address !== exp_r.addr)
                        report_mismatch("payload_address", exp_r.addr, payload_address);
                    case (exp_r.status)
                        STAT_OK:      n_ok++;
                        STAT_NOSPACE: n_nospace++;
                        default:      n_badfree++;
                    endcase
                end
            end
            if (wr_en)
            begin
                if (wr_index == REG_HEAP_BASE)
                begin
                    cfg_base = wr_data;
                    heap_top = wr_data;
                    n_blocks = 0;
                end
                else
                    cfg_limit = wr_data;
            end
            if (start && !busy)
            begin
                if (operation == OP_ALLOC)
                    expected_results.push_back(predict_allocate(request_size));
                else
                    expected_results.push_back(predict_release(release_address));
            end
            if (drain_done && !drained)
            begin
                drained = 1'b1;
                if (expected_results.size() != 0)
                    report_mismatch("transactions left without result",
                                    '0, ADDR_W'(expected_results.size()));
                $display("results checked: %0d ok, %0d no space, %0d bad release",
                         n_ok, n_nospace, n_badfree);
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

// ----- dv/tb_first_fit_heap_allocator.sv -----
// Testbench top for first_fit_heap_allocator: drives config writes and allocate/release
// transactions and gives the verdict. Depends on ffha_pkg and ffha_checker.
module tb_first_fit_heap_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 240;
    localparam int IDLE_PCT     = 24;
    localparam int WATCHDOG_MAX = 5000;
    localparam int LIVE_MAX     = 96;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              wr_en = 1'b0;
    logic              wr_index = REG_HEAP_BASE;
    logic [ADDR_W-1:0] wr_data = '0;
    logic              start = 1'b0;
    logic              busy;
    logic              operation = OP_ALLOC;
    logic [REQ_W-1:0]  request_size = '0;
    logic [ADDR_W-1:0] release_address = '0;
    logic              done;
    logic [1:0]        status;
    logic [ADDR_W-1:0] payload_address;
    logic              drain_done = 1'b0;
    int                outstanding;
    int                fail_count;

    // stimulus bookkeeping
    logic [ADDR_W-1:0] live_addrs[$];   // payload addresses handed out, for releases
    logic [ADDR_W-1:0] cur_base = BASE_RESET;
    int n_alloc, n_release, n_cfg_writes;
    int idle_cycles;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    first_fit_heap_allocator uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .request_size    (request_size),
        .release_address (release_address),
        .done            (done),
        .status          (status),
        .payload_address (payload_address)
    );

    ffha_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .request_size    (request_size),
        .release_address (release_address),
        .done            (done),
        .status          (status),
        .payload_address (payload_address),
        .drain_done      (drain_done),
        .outstanding     (outstanding),
        .fail_count      (fail_count)
    );

    // Harvest granted addresses so releases mostly hit real blocks.
    // A nonzero address with ok status can only come from an allocate.
    always @(posedge clk)
    begin
        if (done && status == STAT_OK && payload_address != '0)
        begin
            live_addrs.push_back(payload_address);
            if (live_addrs.size() > LIVE_MAX)
                void'(live_addrs.pop_front());
        end
    end

    // Watchdog: cycles with no transaction, no result and no config write.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || wr_en)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_MAX);
            $display("first_fit_heap_allocator: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // One transaction. start is left high after acceptance so back-to-back
    // transactions never toggle it within one time step; an optional gap drops
    // it first and lets the running transaction finish, so the gap is time in
    // which the block could have taken a transaction.
    task automatic send_op(input logic op, input logic [REQ_W-1:0] size,
                           input logic [ADDR_W-1:0] addr, input bit may_idle);
        if (may_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while (busy);
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        start           <= 1'b1;
        operation       <= op;
        request_size    <= size;
        release_address <= addr;
        do
            @(posedge clk);
        while (busy);
        if (op == OP_ALLOC)
            n_alloc++;
        else
            n_release++;
    endtask

    // Drop start and wait until every transaction has its result.
    // The first edge lets the checker count a transaction accepted just now.
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Register write; waits for an edge with wr_en low before it ends, so writes
    // never touch wr_en twice in the same step.
    task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        n_cfg_writes++;
        // base write empties the heap
        if (idx == REG_HEAP_BASE)
        begin
            cur_base = data;
            live_addrs.delete();
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] ph_base  [N_PHASES];
        logic [ADDR_W-1:0] ph_limit [N_PHASES];
        bit                ph_set_base [N_PHASES];
        int                ph_alloc_pct [N_PHASES];
        bit                ph_quiet [N_PHASES];
        logic              op;
        logic [REQ_W-1:0]  size;
        logic [ADDR_W-1:0] addr;
        int                r;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed, reset configuration ----------------
        // empty heap: release of the would-be first payload is unknown
        send_op(OP_RELEASE, '0, BASE_RESET + 32'd8, 1'b0);
        send_op(OP_ALLOC, '0, '0, 1'b0);                  // header-only block
        send_op(OP_ALLOC, '1, '0, 1'b0);                  // largest size: past the limit
        send_op(OP_ALLOC, 25'd100, '0, 1'b0);
        send_op(OP_RELEASE, '0, BASE_RESET + 32'd8, 1'b0);
        send_op(OP_RELEASE, '0, BASE_RESET + 32'd8, 1'b0); // already free
        send_op(OP_ALLOC, '0, '0, 1'b0);                  // reuses the freed block
        send_op(OP_RELEASE, '0, BASE_RESET + 32'd9, 1'b0); // not a payload start
        send_op(OP_RELEASE, '0, '0, 1'b0);
        send_op(OP_RELEASE, '0, '1, 1'b0);
        send_op(OP_RELEASE, '0, BASE_RESET + 32'h10, 1'b0); // frees the 108-byte block
        send_op(OP_ALLOC, 25'd50, '0, 1'b0);              // fits the 108-byte hole
        // fill exactly up to the limit, then one header more is too much
        send_op(OP_ALLOC, 25'h13F_FF84, '0, 1'b0);
        send_op(OP_ALLOC, '0, '0, 1'b0);
        wait_idle();
        write_reg(REG_HEAP_LIMIT, '1);                    // limit only: blocks stay
        send_op(OP_ALLOC, '0, '0, 1'b0);
        wait_idle();
        // heap ending right at the top of the address space
        write_reg(REG_HEAP_BASE, 32'hFFFF_FFF0);
        send_op(OP_ALLOC, '0, '0, 1'b0);
        send_op(OP_ALLOC, '0, '0, 1'b0);                  // top would wrap past limit
        send_op(OP_RELEASE, '0, 32'hFFFF_FFF8, 1'b0);
        send_op(OP_ALLOC, 25'd7, '0, 1'b0);               // too big for the hole
        send_op(OP_ALLOC, '0, '0, 1'b0);
        wait_idle();

        // ---------------- random phases ----------------
        ph_base[0] = '0;           ph_limit[0] = '1;
        ph_set_base[0] = 1'b1;     ph_alloc_pct[0] = 60; ph_quiet[0] = 1'b0;
        // tighten the limit under live blocks; long stretch with no gaps
        ph_base[1] = '0;           ph_limit[1] = 32'h800;
        ph_set_base[1] = 1'b0;     ph_alloc_pct[1] = 55; ph_quiet[1] = 1'b1;
        ph_base[2] = ADDR_W'($urandom_range(0, 32'hEFFF_FFFF));
        ph_limit[2] = ph_base[2] + ADDR_W'($urandom_range(64, 4096));
        ph_set_base[2] = 1'b1;     ph_alloc_pct[2] = 60; ph_quiet[2] = 1'b0;
        ph_base[3] = 32'hFFFF_FFF0; ph_limit[3] = '1;
        ph_set_base[3] = 1'b1;     ph_alloc_pct[3] = 50; ph_quiet[3] = 1'b0;
        // base above limit: every append must fail
        ph_base[4] = 32'h1000;     ph_limit[4] = '0;
        ph_set_base[4] = 1'b1;     ph_alloc_pct[4] = 50; ph_quiet[4] = 1'b0;
        ph_base[5] = $urandom;     ph_limit[5] = $urandom;
        ph_set_base[5] = 1'b1;     ph_alloc_pct[5] = 60; ph_quiet[5] = 1'b0;
        ph_base[6] = BASE_RESET;   ph_limit[6] = LIMIT_RESET;
        ph_set_base[6] = 1'b1;     ph_alloc_pct[6] = 80; ph_quiet[6] = 1'b0;
        ph_base[7] = 32'hFFFF_0000; ph_limit[7] = '1;
        ph_set_base[7] = 1'b1;     ph_alloc_pct[7] = 65; ph_quiet[7] = 1'b0;

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (ph_set_base[p])
                write_reg(REG_HEAP_BASE, ph_base[p]);
            write_reg(REG_HEAP_LIMIT, ph_limit[p]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                op = ($urandom_range(0, 99) < ph_alloc_pct[p]) ? OP_ALLOC : OP_RELEASE;
                // sizes: mostly small so holes get reused, some huge
                r = $urandom_range(0, 99);
                if (r < 60)
                    size = REQ_W'($urandom_range(0, 48));
                else if (r < 80)
                    size = REQ_W'($urandom_range(0, 4095));
                else if (r < 90)
                    size = REQ_W'($urandom);
                else if (r < 95)
                    size = '0;
                else
                    size = '1;
                // addresses: mostly granted ones, some near misses and noise
                r = $urandom_range(0, 99);
                if (r < 55 && live_addrs.size() != 0)
                    addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
                else if (r < 70 && live_addrs.size() != 0)
                    addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)]
                           + ADDR_W'($urandom_range(0, 16)) - 32'd8;
                else if (r < 80)
                    addr = cur_base + 32'd8;
                else
                    addr = $urandom;
                send_op(op, size, addr, !ph_quiet[p]);
            end
            wait_idle();
        end

        // ---------------- drain ----------------
        wait_idle();
        repeat (2 * MAX_BLOCKS + 4) @(posedge clk);
        drain_done <= 1'b1;
        repeat (3) @(posedge clk);
        $display("%0d allocates, %0d releases, %0d register writes over %0d heap setups",
                 n_alloc, n_release, n_cfg_writes, N_PHASES + 3);
        if (fail_count == 0)
            $display("first_fit_heap_allocator: match");
        else
            $display("first_fit_heap_allocator: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_table_ram.sv
hw/rtl/first_fit_heap_allocator.sv
dv/ffha_checker.sv
dv/tb_first_fit_heap_allocator.sv
